### src/bsht_pkg.sv
// Package for the bucketed sorted hash table: codes, command/status structs,
// controller states and configuration helpers.
// No dependencies.
package bsht_pkg;

  localparam int DEF_MAX_FLOORS = 64;
  localparam int DEF_MAX_SLOTS  = 16;

  localparam int KEY_W       = 31;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int FLOOR_OUT_W = 6;
  localparam int SLOT_OUT_W  = 4;
  localparam int INIT_W      = 7;
  localparam int SPF_W       = 5;
  localparam int CFG_DW      = 32;
  localparam int CFG_AW      = 3;

  localparam logic [INIT_W-1:0] INIT_RST = 7'd1;
  localparam logic [SPF_W-1:0]  SPF_RST  = 5'd16;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_FLOORS = 1'b0;
  localparam logic CFG_IDX_SLOTS  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_DIV_START,
    DP_DIV_TAKE,
    DP_FILL_TAKE,
    DP_NEXT_FLOOR,
    DP_LB_RD,
    DP_LB_STEP,
    DP_SH_START,
    DP_SH_RD,
    DP_SH_WR,
    DP_INS_WR,
    DP_FD_RD,
    DP_MARK,
    DP_RB_INIT,
    DP_SCAN_RD,
    DP_SCAN_TAKE,
    DP_RB_GROW,
    DP_LIVE_TAKE,
    DP_KEY_TAKE,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic            set_res;
    logic [ST_W-1:0] res_st;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic grow_ovf;
    logic div_busy;
    logic fill_full;
    logic lb_open;
    logic pos_in;
    logic fd_match;
    logic fd_removed;
    logic probe_last;
    logic sh_more;
    logic scan_more;
    logic live_more;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV_GO,
    S_DIV_WT,
    S_FILL_RD,
    S_FILL_WT,
    S_LB_CHK,
    S_LB_WT,
    S_SH_CHK,
    S_SH_WT,
    S_FD_WT,
    S_RB_FILL_RD,
    S_RB_FILL_WT,
    S_RB_SCAN,
    S_RB_SCAN_WT,
    S_RB_LIVE,
    S_RB_LIVE_WT,
    S_FIN
  } ctl_state_t;

  // clamp a register value into 1..mx
  function automatic int clamp_cfg(input int v, input int mx);
    int r;
    r = v;
    if (r < 1) r = 1;
    if (r > mx) r = mx;
    return r;
  endfunction

endpackage

### src/bucketed_sorted_hash_table.sv
// Top level of the bucketed sorted hash table: controller plus datapath.
// Depends on bsht_pkg, bsht_ctrl, bsht_dp (and through it bsht_ram, bsht_mod).
//
// Usage
//   Input channel (in_valid/in_ready, in_op, in_key): one item per operation,
//   add, query or remove. Output channel (out_valid/out_ready, out_status,
//   out_floor, out_slot): exactly one result item per input item, in order.
//   APB-style config port: initial_floors at 0x0, slots_per_floor at 0x4;
//   a write empties the table. Write only while the block is idle.
// Timing
//   One item at a time. Work on an item, step by step:
//     accept, dispatch, bit-serial key mod floor count, then the result
//     + per probed floor: fill read, binary-search steps (ceil(log2(fill+1))),
//       then a lookup read on query or remove; a full floor is skipped on add
//     + on add: each entry from the insert slot up is shifted up, then the write.
//   An add into a full table first rebuilds: each old floor's fill is read and
//   every old entry scanned, then one full insert (as above) per live key.
//   The single-port-per-side entry RAM and the serial mod unit set how long each step takes.
// Reset
//   Synchronous, active low: table empty, floors = 1, slots per floor = 16.
// Stall
//   A result waits in the output register; the next item is already accepted
//   and worked on, and the block holds its next result until out_ready.
module bucketed_sorted_hash_table import bsht_pkg::*; #(
  parameter int MAX_FLOORS = DEF_MAX_FLOORS,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        in_op,
  input  logic [KEY_W-1:0]       in_key,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [FLOOR_OUT_W-1:0] out_floor,
  output logic [SLOT_OUT_W-1:0]  out_slot,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // zero-wait-state register port
  assign pready = 1'b1;

  bsht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsht_dp #(
    .MAX_FLOORS (MAX_FLOORS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_op),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_floor  (out_floor),
    .out_slot   (out_slot),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
  );

endmodule

### src/bsht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bsht_mod.sv
// Bit-serial restoring remainder unit: key mod floor count, one bit per cycle.
// Depends on bsht_pkg.
module bsht_mod import bsht_pkg::*; #(
  parameter int DW = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             busy,
  output logic [DW-1:0]    rem
);

  localparam int CW = $clog2(KEY_W + 1);

  logic             busy_r, busy_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [KEY_W-1:0] sh_r, sh_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW:0]      trial;

  assign trial = {rem_r, sh_r[KEY_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(KEY_W);
      sh_nxt   = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DW-1:0];
      end
      sh_nxt  = {sh_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

### src/bsht_dp.sv
// Datapath: table storage, probe/search/shift registers, config and result regs.
// Depends on bsht_pkg, bsht_ram, bsht_mod.
module bsht_dp import bsht_pkg::*; #(
  parameter int MAX_FLOORS = DEF_MAX_FLOORS,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_cmd_t               cmd,
  output dp_stat_t               stat,
  input  logic [OP_W-1:0]        in_op,
  input  logic [KEY_W-1:0]       in_key,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ST_W-1:0]        out_status,
  output logic [FLOOR_OUT_W-1:0] out_floor,
  output logic [SLOT_OUT_W-1:0]  out_slot,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata
);

  localparam int TOTAL = MAX_FLOORS * MAX_SLOTS;
  localparam int FW    = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
  localparam int FCW   = $clog2(MAX_FLOORS + 1);
  localparam int SW    = $clog2(MAX_SLOTS + 1);
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int NW    = $clog2(TOTAL + 1);
  localparam int EW    = KEY_W + 1;

  op_t                   op_r, op_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [KEY_W-1:0]      ins_key_r, ins_key_nxt;
  logic [FW-1:0]         f_r, f_nxt, i_r, i_nxt;
  logic [SW-1:0]         lo_r, lo_nxt, hi_r, hi_nxt, k_r, k_nxt;
  logic [SW-1:0]         j_r, j_nxt, fill_r, fill_nxt;
  logic [NW-1:0]         n_r, n_nxt, lj_r, lj_nxt, used_r, used_nxt;
  logic [FCW-1:0]        fc_r, fc_nxt;
  logic [MAX_FLOORS-1:0] valid_r, valid_nxt;
  logic [INIT_W-1:0]     init_r, init_nxt;
  logic [SPF_W-1:0]      spf_r, spf_nxt;
  logic [ST_W-1:0]       res_st_r, res_st_nxt;
  logic [FLOOR_OUT_W-1:0] res_f_r, res_f_nxt;
  logic [SLOT_OUT_W-1:0] res_s_r, res_s_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]       out_status_r, out_status_nxt;
  logic [FLOOR_OUT_W-1:0] out_floor_r, out_floor_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;

  logic [SW-1:0]  s_eff, fill_q, fill_eff, mid;
  logic [SW:0]    lh_sum;
  logic [NW-1:0]  base, cap;
  logic [FCW:0]   newn;
  logic [31:0]    f_wide, lo_wide;
  logic           cfg_we;

  logic           ent_we;
  logic [AW-1:0]  ent_waddr, ent_raddr;
  logic [EW-1:0]  ent_wdata, ent_q;
  logic           fill_we;
  logic [SW-1:0]  fill_wdata;
  logic           live_we;
  logic [KEY_W-1:0] live_q;
  logic           div_start, div_busy;
  logic [FCW-1:0] div_rem;

  assign s_eff    = SW'(clamp_cfg(int'(spf_r), MAX_SLOTS));
  assign fill_eff = valid_r[f_r] ? fill_q : '0;
  assign lh_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = lh_sum[SW:1];
  assign base     = NW'(f_r) * NW'(s_eff);
  assign cap      = NW'(fc_r) * NW'(s_eff);
  assign newn     = {fc_r, 1'b1};
  assign f_wide   = 32'(f_r);
  assign lo_wide  = 32'(lo_r);
  assign cfg_we   = psel & penable & pwrite;

  bsht_ram #(.WIDTH(EW), .DEPTH(TOTAL)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_q)
  );

  bsht_ram #(.WIDTH(SW), .DEPTH(MAX_FLOORS)) u_fill_ram (
    .clk(clk), .we(fill_we), .waddr(f_r), .wdata(fill_wdata),
    .raddr(f_r), .rdata(fill_q)
  );

  bsht_ram #(.WIDTH(KEY_W), .DEPTH(TOTAL)) u_live_ram (
    .clk(clk), .we(live_we), .waddr(n_r[AW-1:0]), .wdata(ent_q[KEY_W-1:0]),
    .raddr(lj_r[AW-1:0]), .rdata(live_q)
  );

  bsht_mod #(.DW(FCW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(ins_key_r),
    .divisor(fc_r), .busy(div_busy), .rem(div_rem)
  );

  always_comb begin
    stat.op         = op_r;
    stat.full       = used_r >= cap;
    stat.grow_ovf   = newn > (FCW+1)'(MAX_FLOORS);
    stat.div_busy   = div_busy;
    stat.fill_full  = fill_eff >= s_eff;
    stat.lb_open    = lo_r < hi_r;
    stat.pos_in     = lo_r < fill_r;
    stat.fd_match   = ent_q[KEY_W-1:0] == ins_key_r;
    stat.fd_removed = ent_q[KEY_W];
    stat.probe_last = (FCW'(i_r) + FCW'(1)) == fc_r;
    stat.sh_more    = k_r > lo_r;
    stat.scan_more  = j_r < fill_r;
    stat.live_more  = lj_r < n_r;
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    ins_key_nxt    = ins_key_r;
    f_nxt          = f_r;
    i_nxt          = i_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    fill_nxt       = fill_r;
    n_nxt          = n_r;
    lj_nxt         = lj_r;
    used_nxt       = used_r;
    fc_nxt         = fc_r;
    valid_nxt      = valid_r;
    init_nxt       = init_r;
    spf_nxt        = spf_r;
    res_st_nxt     = res_st_r;
    res_f_nxt      = res_f_r;
    res_s_nxt      = res_s_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_floor_nxt  = out_floor_r;
    out_slot_nxt   = out_slot_r;
    ent_we         = 1'b0;
    ent_waddr      = '0;
    ent_wdata      = '0;
    ent_raddr      = '0;
    fill_we        = 1'b0;
    fill_wdata     = fill_r + SW'(1);
    live_we        = 1'b0;
    div_start      = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (cmd.op)
      DP_ACCEPT: begin
        op_nxt      = op_t'(in_op);
        key_nxt     = in_key;
        ins_key_nxt = in_key;
      end
      DP_DIV_START: div_start = 1'b1;
      DP_DIV_TAKE: begin
        f_nxt = div_rem[FW-1:0];
        i_nxt = '0;
      end
      DP_FILL_TAKE: begin
        fill_nxt = fill_eff;
        lo_nxt   = '0;
        hi_nxt   = fill_eff;
        j_nxt    = '0;
      end
      DP_NEXT_FLOOR: begin
        i_nxt = i_r + FW'(1);
        if ((FCW'(f_r) + FCW'(1)) == fc_r) f_nxt = '0;
        else f_nxt = f_r + FW'(1);
      end
      DP_LB_RD: ent_raddr = AW'(base + NW'(mid));
      DP_LB_STEP: begin
        if (ins_key_r <= ent_q[KEY_W-1:0]) hi_nxt = mid;
        else lo_nxt = mid + SW'(1);
      end
      DP_SH_START: k_nxt = fill_r;
      DP_SH_RD: ent_raddr = AW'(base + NW'(k_r - SW'(1)));
      DP_SH_WR: begin
        ent_we    = 1'b1;
        ent_waddr = AW'(base + NW'(k_r));
        ent_wdata = ent_q;
        k_nxt     = k_r - SW'(1);
      end
      DP_INS_WR: begin
        ent_we          = 1'b1;
        ent_waddr       = AW'(base + NW'(lo_r));
        ent_wdata       = {1'b0, ins_key_r};
        fill_we         = 1'b1;
        valid_nxt[f_r]  = 1'b1;
        used_nxt        = used_r + NW'(1);
      end
      DP_FD_RD: ent_raddr = AW'(base + NW'(lo_r));
      DP_MARK: begin
        ent_we    = 1'b1;
        ent_waddr = AW'(base + NW'(lo_r));
        ent_wdata = {1'b1, ins_key_r};
      end
      DP_RB_INIT: begin
        f_nxt = '0;
        i_nxt = '0;
        n_nxt = '0;
      end
      DP_SCAN_RD: ent_raddr = AW'(base + NW'(j_r));
      DP_SCAN_TAKE: begin
        if (!ent_q[KEY_W]) begin
          live_we = 1'b1;
          n_nxt   = n_r + NW'(1);
        end
        j_nxt = j_r + SW'(1);
      end
      DP_RB_GROW: begin
        valid_nxt = '0;
        fc_nxt    = newn[FCW-1:0];
        used_nxt  = '0;
        lj_nxt    = '0;
      end
      DP_LIVE_TAKE: begin
        ins_key_nxt = live_q;
        lj_nxt      = lj_r + NW'(1);
      end
      DP_KEY_TAKE: ins_key_nxt = key_r;
      DP_PUBLISH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_st_r;
        out_floor_nxt  = res_f_r;
        out_slot_nxt   = res_s_r;
      end
      default: ;
    endcase

    if (cmd.set_res) begin
      res_st_nxt = cmd.res_st;
      if (cmd.res_st == ST_OK) begin
        res_f_nxt = f_wide[FLOOR_OUT_W-1:0];
        res_s_nxt = lo_wide[SLOT_OUT_W-1:0];
      end else begin
        res_f_nxt = '0;
        res_s_nxt = '0;
      end
    end

    // any register write empties the table
    if (cfg_we) begin
      valid_nxt = '0;
      used_nxt  = '0;
      if (paddr[2] == CFG_IDX_FLOORS) begin
        init_nxt = pwdata[INIT_W-1:0];
        fc_nxt   = FCW'(clamp_cfg(int'(pwdata[INIT_W-1:0]), MAX_FLOORS));
      end else begin
        spf_nxt = pwdata[SPF_W-1:0];
        fc_nxt  = FCW'(clamp_cfg(int'(init_r), MAX_FLOORS));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      used_r      <= '0;
      fc_r        <= FCW'(clamp_cfg(int'(INIT_RST), MAX_FLOORS));
      init_r      <= INIT_RST;
      spf_r       <= SPF_RST;
      out_valid_r <= 1'b0;
      op_r        <= OP_NOP;
    end else begin
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      fc_r        <= fc_nxt;
      init_r      <= init_nxt;
      spf_r       <= spf_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
    key_r        <= key_nxt;
    ins_key_r    <= ins_key_nxt;
    f_r          <= f_nxt;
    i_r          <= i_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    k_r          <= k_nxt;
    j_r          <= j_nxt;
    fill_r       <= fill_nxt;
    n_r          <= n_nxt;
    lj_r         <= lj_nxt;
    res_st_r     <= res_st_nxt;
    res_f_r      <= res_f_nxt;
    res_s_r      <= res_s_nxt;
    out_status_r <= out_status_nxt;
    out_floor_r  <= out_floor_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_floor  = out_floor_r;
  assign out_slot   = out_slot_r;
  assign prdata     = (paddr[2] == CFG_IDX_FLOORS) ? CFG_DW'(init_r) : CFG_DW'(spf_r);

endmodule

### src/bsht_ctrl.sv
// Controller FSM: sequences probe, binary search, shift, lookup and rebuild.
// Depends on bsht_pkg.
module bsht_ctrl import bsht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       rb_r, rb_nxt;   // inserting live keys of a rebuild

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rb_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rb_r    <= rb_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rb_nxt      = rb_r;
    in_ready    = 1'b0;
    cmd.op      = DP_NONE;
    cmd.set_res = 1'b0;
    cmd.res_st  = ST_OK;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        rb_nxt = 1'b0;
        case (stat.op)
          OP_ADD: begin
            if (stat.full) begin
              if (stat.grow_ovf) begin
                cmd.set_res = 1'b1;
                cmd.res_st  = ST_OVF;
                state_nxt   = S_FIN;
              end else begin
                cmd.op    = DP_RB_INIT;
                state_nxt = S_RB_FILL_RD;
              end
            end else begin
              state_nxt = S_DIV_GO;
            end
          end
          OP_QUERY, OP_REMOVE: state_nxt = S_DIV_GO;
          default: begin
            cmd.set_res = 1'b1;
            cmd.res_st  = ST_MISS;
            state_nxt   = S_FIN;
          end
        endcase
      end
      S_DIV_GO: begin
        cmd.op    = DP_DIV_START;
        state_nxt = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (!stat.div_busy) begin
          cmd.op    = DP_DIV_TAKE;
          state_nxt = S_FILL_RD;
        end
      end
      S_FILL_RD: state_nxt = S_FILL_WT;
      S_FILL_WT: begin
        if (stat.op == OP_ADD && stat.fill_full) begin
          if (stat.probe_last) begin
            cmd.set_res = 1'b1;
            cmd.res_st  = ST_OVF;
            state_nxt   = S_FIN;
          end else begin
            cmd.op    = DP_NEXT_FLOOR;
            state_nxt = S_FILL_RD;
          end
        end else begin
          cmd.op    = DP_FILL_TAKE;
          state_nxt = S_LB_CHK;
        end
      end
      S_LB_CHK: begin
        if (stat.lb_open) begin
          cmd.op    = DP_LB_RD;
          state_nxt = S_LB_WT;
        end else if (stat.op == OP_ADD) begin
          cmd.op    = DP_SH_START;
          state_nxt = S_SH_CHK;
        end else if (stat.pos_in) begin
          cmd.op    = DP_FD_RD;
          state_nxt = S_FD_WT;
        end else if (stat.probe_last) begin
          cmd.set_res = 1'b1;
          cmd.res_st  = ST_MISS;
          state_nxt   = S_FIN;
        end else begin
          cmd.op    = DP_NEXT_FLOOR;
          state_nxt = S_FILL_RD;
        end
      end
      S_LB_WT: begin
        cmd.op    = DP_LB_STEP;
        state_nxt = S_LB_CHK;
      end
      S_SH_CHK: begin
        if (stat.sh_more) begin
          cmd.op    = DP_SH_RD;
          state_nxt = S_SH_WT;
        end else begin
          cmd.op = DP_INS_WR;
          if (rb_r) begin
            state_nxt = S_RB_LIVE;
          end else begin
            cmd.set_res = 1'b1;
            cmd.res_st  = ST_OK;
            state_nxt   = S_FIN;
          end
        end
      end
      S_SH_WT: begin
        cmd.op    = DP_SH_WR;
        state_nxt = S_SH_CHK;
      end
      S_FD_WT: begin
        if (stat.fd_match) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_FIN;
          if (stat.op == OP_REMOVE) begin
            cmd.op     = DP_MARK;
            cmd.res_st = ST_OK;
          end else begin
            cmd.res_st = stat.fd_removed ? ST_MISS : ST_OK;
          end
        end else if (stat.probe_last) begin
          cmd.set_res = 1'b1;
          cmd.res_st  = ST_MISS;
          state_nxt   = S_FIN;
        end else begin
          cmd.op    = DP_NEXT_FLOOR;
          state_nxt = S_FILL_RD;
        end
      end
      S_RB_FILL_RD: state_nxt = S_RB_FILL_WT;
      S_RB_FILL_WT: begin
        cmd.op    = DP_FILL_TAKE;
        state_nxt = S_RB_SCAN;
      end
      S_RB_SCAN: begin
        if (stat.scan_more) begin
          cmd.op    = DP_SCAN_RD;
          state_nxt = S_RB_SCAN_WT;
        end else if (stat.probe_last) begin
          cmd.op    = DP_RB_GROW;
          rb_nxt    = 1'b1;
          state_nxt = S_RB_LIVE;
        end else begin
          cmd.op    = DP_NEXT_FLOOR;
          state_nxt = S_RB_FILL_RD;
        end
      end
      S_RB_SCAN_WT: begin
        cmd.op    = DP_SCAN_TAKE;
        state_nxt = S_RB_SCAN;
      end
      S_RB_LIVE: begin
        if (stat.live_more) begin
          state_nxt = S_RB_LIVE_WT;
        end else begin
          cmd.op    = DP_KEY_TAKE;
          rb_nxt    = 1'b0;
          state_nxt = S_DIV_GO;
        end
      end
      S_RB_LIVE_WT: begin
        cmd.op    = DP_LIVE_TAKE;
        state_nxt = S_DIV_GO;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = DP_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### src/bsht_checker.sv
// Port-level checker for bucketed_sorted_hash_table, bound to the top level.
// Depends on bsht_pkg.
module bsht_checker import bsht_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [ST_W-1:0]        out_status,
  input logic [FLOOR_OUT_W-1:0] out_floor,
  input logic [SLOT_OUT_W-1:0]  out_slot
);

  // one item in flight: an accept closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_MISS || out_status == ST_OVF))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_floor == '0 && out_slot == '0)
    else $error("failed result carries a location");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_floor) && $stable(out_slot))
    else $error("stalled result changed");

endmodule

bind bucketed_sorted_hash_table bsht_checker u_bsht_checker (.*);
